FILE: hw/rtl/ttwc_pkg.sv
// ttwc_pkg: shared types, character codes and token kinds for the text tokenizer
// no dependencies; imported by text_tokenizer_with_comments_unit

package ttwc_pkg;

  localparam int unsigned TDATA_IN_BITS  = 8;
  localparam int unsigned TDATA_OUT_BITS = 40;
  localparam int unsigned LEN_BITS       = 16;
  localparam int unsigned START_BITS     = 16;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // token kinds as reported on the output
  typedef enum logic [2:0] {
    KIND_SYMBOL      = 3'd0,
    KIND_BLOCK_OPEN  = 3'd1,
    KIND_BLOCK_CLOSE = 3'd2,
    KIND_TUPLE_OPEN  = 3'd3,
    KIND_TUPLE_CLOSE = 3'd4,
    KIND_STRING      = 3'd5,
    KIND_NUMBER      = 3'd6,
    KIND_INVALID     = 3'd7
  } kind_t;

  // lexer modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE       = 8'b0000_0001,
    MODE_SLASH      = 8'b0000_0010,
    MODE_BLOCK      = 8'b0000_0100,
    MODE_BLOCK_STAR = 8'b0000_1000,
    MODE_LINE       = 8'b0001_0000,
    MODE_STRING     = 8'b0010_0000,
    MODE_NUMBER     = 8'b0100_0000,
    MODE_SYMBOL     = 8'b1000_0000
  } mode_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit_start(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_MINUS);
  endfunction

endpackage

FILE: hw/rtl/text_tokenizer_with_comments_unit.sv
// text_tokenizer_with_comments_unit: streaming byte tokenizer with comment skipping
// one-byte mode update feeding a result register; depends on ttwc_pkg
//
// a token appears on the master side in the cycle after the byte that completes it is accepted
// throughput: one byte per cycle; the lexer mode and pending token update with each accepted byte
// input stalls only while the result register holds a token the sink has not taken
// reset: synchronous rst returns the lexer to idle, clears position and pending token,
// and empties the result register

module text_tokenizer_with_comments_unit #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] byte_in
  input  logic [ttwc_pkg::TDATA_IN_BITS-1:0]   s_axis_tdata,
  // end_of_stream
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] token_kind, [18:3] token_start, [34:19] token_length, [39:35] zero
  output logic [ttwc_pkg::TDATA_OUT_BITS-1:0]  m_axis_tdata,
  // at_end
  output logic                                 m_axis_tlast
);

  import ttwc_pkg::*;

  mode_t                     mode, mode_next;
  logic [POSITION_BITS-1:0]  byte_position, byte_position_next;
  logic [POSITION_BITS-1:0]  pending_start, pending_start_next;
  logic [LEN_BITS-1:0]       pending_length, pending_length_next;

  logic                      out_valid;
  kind_t                     out_kind, out_kind_next;
  logic [START_BITS-1:0]     out_start, out_start_next;
  logic [LEN_BITS-1:0]       out_length, out_length_next;
  logic                      out_last;
  logic                      emit;

  logic                      accept;
  logic [7:0]                c;
  logic                      eos;
  logic [LEN_BITS-1:0]       len_grown;
  logic [POSITION_BITS+START_BITS-1:0] start_wide;
  logic [POSITION_BITS+START_BITS-1:0] pos_wide;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata[7:0];
  assign eos           = s_axis_tlast;
  assign len_grown     = (pending_length != LEN_MAX) ? pending_length + 1'b1 : pending_length;

  // low bits of the position, zero-extended when the counter is narrow
  assign pos_wide   = {{START_BITS{1'b0}}, byte_position};

  always_comb begin
    mode_next           = mode;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    emit                = 1'b0;
    out_kind_next       = KIND_SYMBOL;
    out_start_next      = pos_wide[START_BITS-1:0];
    out_length_next     = LEN_BITS'(1);

    unique case (mode)
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else if (c == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (is_ws(c)) begin
          emit          = 1'b1;
          out_kind_next = KIND_SYMBOL;
          mode_next     = MODE_IDLE;
        end else begin
          pending_length_next = len_grown;
          mode_next           = MODE_SYMBOL;
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) mode_next = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          mode_next = MODE_IDLE;
        end else if (c != CH_STAR) begin
          mode_next = MODE_BLOCK;
        end
      end
      MODE_LINE: begin
        if (c == CH_NEWLINE) mode_next = MODE_IDLE;
      end
      MODE_STRING: begin
        pending_length_next = len_grown;
        if (c == CH_QUOTE) begin
          emit          = 1'b1;
          out_kind_next = KIND_STRING;
          mode_next     = MODE_IDLE;
        end
      end
      MODE_NUMBER, MODE_SYMBOL: begin
        if (is_ws(c)) begin
          emit          = 1'b1;
          out_kind_next = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
          mode_next     = MODE_IDLE;
        end else begin
          pending_length_next = len_grown;
        end
      end
      default: begin
        // idle between tokens
        if (is_ws(c)) begin
          mode_next = MODE_IDLE;
        end else if ((c == CH_LBRACE) || (c == CH_RBRACE) ||
                     (c == CH_LPAREN) || (c == CH_RPAREN)) begin
          emit = 1'b1;
          priority if (c == CH_LBRACE) out_kind_next = KIND_BLOCK_OPEN;
          else if (c == CH_RBRACE)     out_kind_next = KIND_BLOCK_CLOSE;
          else if (c == CH_LPAREN)     out_kind_next = KIND_TUPLE_OPEN;
          else                         out_kind_next = KIND_TUPLE_CLOSE;
        end else begin
          pending_start_next  = byte_position;
          pending_length_next = LEN_BITS'(1);
          priority if (c == CH_SLASH)  mode_next = MODE_SLASH;
          else if (c == CH_QUOTE)      mode_next = MODE_STRING;
          else if (is_digit_start(c))  mode_next = MODE_NUMBER;
          else                         mode_next = MODE_SYMBOL;
        end
      end
    endcase

    // start of the pending token, taken before the end-of-stream clear
    start_wide = {{START_BITS{1'b0}}, pending_start_next};

    // pending token fields for every token that was not a delimiter
    if (emit && (mode != MODE_IDLE)) begin
      out_start_next  = start_wide[START_BITS-1:0];
      out_length_next = pending_length_next;
    end

    byte_position_next = byte_position + 1'b1;

    if (eos) begin
      // unfinished token at the last byte becomes invalid
      if (!emit && ((mode_next == MODE_SLASH) || (mode_next == MODE_STRING) ||
                    (mode_next == MODE_NUMBER) || (mode_next == MODE_SYMBOL))) begin
        emit            = 1'b1;
        out_kind_next   = KIND_INVALID;
        out_start_next  = start_wide[START_BITS-1:0];
        out_length_next = pending_length_next;
      end
      mode_next           = MODE_IDLE;
      byte_position_next  = '0;
      pending_start_next  = '0;
      pending_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      byte_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode           <= mode_next;
        byte_position  <= byte_position_next;
        pending_start  <= pending_start_next;
        pending_length <= pending_length_next;
        out_valid      <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind   <= out_kind_next;
      out_start  <= out_start_next;
      out_length <= out_length_next;
      out_last   <= eos;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_length, out_start, out_kind};
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  a_invalid_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[2:0] == KIND_INVALID)) |-> m_axis_tlast)
    else $error("invalid token reported without end of stream");

  a_delim_length_one: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((out_kind == KIND_BLOCK_OPEN) || (out_kind == KIND_BLOCK_CLOSE) ||
                       (out_kind == KIND_TUPLE_OPEN) || (out_kind == KIND_TUPLE_CLOSE)))
    |-> (out_length == LEN_BITS'(1)))
    else $error("delimiter token with length other than one");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> ((mode == MODE_IDLE) && (byte_position == '0) &&
                                  (pending_length == '0)))
    else $error("lexer not back at start after last byte");

  a_position_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_axis_tlast) |=>
    (byte_position == POSITION_BITS'($past(byte_position) + 1'b1)))
    else $error("byte position did not advance by one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(mode) && $stable(byte_position)))
    else $error("lexer state moved without an accepted request");
`endif

endmodule
